// ===== hdl/i2cm_pkg.sv =====
// Package for the I2C bit-level master core: word types, sequencer state type and codes.
// Used by every module of the core; depends on nothing.
`default_nettype none

package i2cm_pkg;

   localparam int HOLD_W = 16;
   localparam logic [HOLD_W-1:0] HALF_PERIOD_RESET = 16'd50;

   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_ACK   = 3'd4;
   localparam logic [2:0] CMD_NACK  = 3'd5;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_STOP  = 3'd2;
   localparam logic [2:0] PH_WRITE = 3'd3;
   localparam logic [2:0] PH_READ  = 3'd4;
   localparam logic [2:0] PH_ACK   = 3'd5;
   localparam logic [2:0] PH_NACK  = 3'd6;

   localparam logic [1:0] SEG_FIRST  = 2'd0;
   localparam logic [1:0] SEG_SECOND = 2'd1;
   localparam logic [1:0] SEG_THIRD  = 2'd2;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] cmd;
      logic [7:0] wr_byte;
      logic       sda_in;
   } i2cm_req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_byte;
      logic       ack_bit;
   } i2cm_rsp_type;

   typedef struct packed {
      logic [2:0]        phase;
      logic [1:0]        step_index;
      logic [3:0]        bit_count;
      logic [7:0]        shift_reg;
      logic [HOLD_W-1:0] hold_count;
      logic              scl;
      logic              sda;
      logic              sda_drive;
      logic              ack;
      logic [7:0]        rd_byte;
   } i2cm_state_type;

   localparam i2cm_state_type STATE_RESET = '{
      phase:      PH_IDLE,
      step_index: SEG_FIRST,
      bit_count:  4'd0,
      shift_reg:  8'h00,
      hold_count: '0,
      scl:        1'b1,
      sda:        1'b1,
      sda_drive:  1'b0,
      ack:        1'b0,
      rd_byte:    8'h00
   };

endpackage

`default_nettype wire

// ===== hdl/i2c_bit_level_master_core.sv =====
// Top level of the I2C bit-level master: sequencer state, half-period register, result register.
// Depends on i2cm_pkg and i2cm_step.
//
// Each word on the req_ channel is one bus tick: the sampled SDA level and, while the
// sequencer is idle, an optional command (start, stop, write, read, ack, nack). For every
// accepted req_ word exactly one rsp_ word is produced, carrying the SCL level, SDA level
// and drive enable, busy and done flags, the last read byte and the last ACK bit.
// The state is updated at the edge that accepts a req_ word, and the rsp_ word is loaded
// into the result register at that same edge; a new word is taken every cycle while results
// are taken. The result register parts the two sides: req_ready is high whenever the
// result register is empty or being drained at the same edge. When the receiver holds
// rsp_ready low, the result stays put and req_ready drops until it is taken.
// The csr_ port writes half_period_ticks (the ticks each line level is held, zero acting
// as one); it is always ready and should only be written while the sequencer is idle.
// A synchronous reset empties the result register, idles the sequencer with SCL and SDA
// high and SDA released, and sets half_period_ticks to 50.
`default_nettype none

module i2c_bit_level_master_core
   import i2cm_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire i2cm_req_type      req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output i2cm_rsp_type           rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire logic [HOLD_W-1:0] csr_data
);

   i2cm_state_type    state_ff, state_in;
   logic [HOLD_W-1:0] half_period_ff, half_period_in;
   logic              rsp_valid_ff, rsp_valid_in;
   i2cm_rsp_type      rsp_data_ff, rsp_data_in;
   logic              step_done;
   logic              req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   i2cm_step u_step (
      .cur_state   (state_ff),
      .req         (req_data),
      .half_period (half_period_ff),
      .nxt_state   (state_in),
      .done        (step_done)
   );

   always_comb begin
      rsp_data_in.scl_level = state_in.scl;
      rsp_data_in.sda_level = state_in.sda;
      rsp_data_in.sda_drive = state_in.sda_drive;
      rsp_data_in.busy_res  = (state_in.phase != PH_IDLE);
      rsp_data_in.done_res  = step_done;
      rsp_data_in.rd_byte   = state_in.rd_byte;
      rsp_data_in.ack_bit   = state_in.ack;
   end

   assign rsp_valid_in   = req_fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign half_period_in = (csr_valid && csr_ready) ? csr_data : half_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= STATE_RESET;
         half_period_ff <= HALF_PERIOD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         half_period_ff <= half_period_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/i2cm_step.sv =====
// Next-state logic of the I2C bit-level master: one bus tick applied to the sequencer state.
// Purely combinational; depends on i2cm_pkg.
`default_nettype none

module i2cm_step
   import i2cm_pkg::*;
(
   input  wire i2cm_state_type    cur_state,
   input  wire i2cm_req_type      req,
   input  wire logic [HOLD_W-1:0] half_period,
   output i2cm_state_type         nxt_state,
   output logic                   done
);

   logic [HOLD_W-1:0] hold_len;
   logic [HOLD_W-1:0] hold_dec;
   logic [3:0]        bit_inc;
   logic [7:0]        shift_left;

   assign hold_len   = (half_period == '0) ? {{(HOLD_W-1){1'b0}}, 1'b1} : half_period;
   assign hold_dec   = (cur_state.hold_count != '0) ?
                       cur_state.hold_count - {{(HOLD_W-1){1'b0}}, 1'b1} : '0;
   assign bit_inc    = cur_state.bit_count + 4'd1;
   assign shift_left = {cur_state.shift_reg[6:0], 1'b0};

   always_comb begin
      nxt_state = cur_state;
      done      = 1'b0;
      if (cur_state.phase == PH_IDLE) begin
         if (req.cmd_valid && (req.cmd inside {[CMD_START:CMD_NACK]})) begin
            nxt_state.bit_count  = 4'd0;
            nxt_state.step_index = SEG_FIRST;
            nxt_state.hold_count = hold_len;
            case (req.cmd)
               CMD_START: begin
                  nxt_state.phase     = PH_START;
                  nxt_state.sda_drive = 1'b1;
                  nxt_state.sda       = 1'b1;
                  nxt_state.scl       = 1'b1;
               end
               CMD_STOP: begin
                  nxt_state.phase     = PH_STOP;
                  nxt_state.sda_drive = 1'b1;
                  nxt_state.sda       = 1'b0;
               end
               CMD_WRITE: begin
                  nxt_state.phase     = PH_WRITE;
                  nxt_state.shift_reg = req.wr_byte;
                  nxt_state.sda_drive = 1'b1;
                  nxt_state.sda       = req.wr_byte[7];
               end
               CMD_READ: begin
                  nxt_state.phase     = PH_READ;
                  nxt_state.shift_reg = 8'h00;
                  nxt_state.sda_drive = 1'b0;
               end
               CMD_ACK: begin
                  nxt_state.phase     = PH_ACK;
                  nxt_state.sda_drive = 1'b1;
                  nxt_state.sda       = 1'b0;
               end
               default: begin
                  nxt_state.phase     = PH_NACK;
                  nxt_state.sda_drive = 1'b1;
                  nxt_state.sda       = 1'b1;
               end
            endcase
         end
      end else begin
         nxt_state.hold_count = hold_dec;
         if (hold_dec == '0) begin
            case (cur_state.phase)
               PH_START: begin
                  if (cur_state.step_index == SEG_FIRST) begin
                     nxt_state.sda        = 1'b0;
                     nxt_state.step_index = SEG_SECOND;
                     nxt_state.hold_count = hold_len;
                  end else begin
                     nxt_state.scl = 1'b0;
                     done          = 1'b1;
                  end
               end
               PH_STOP: begin
                  if (cur_state.step_index == SEG_FIRST) begin
                     nxt_state.scl        = 1'b1;
                     nxt_state.step_index = SEG_SECOND;
                     nxt_state.hold_count = hold_len;
                  end else begin
                     nxt_state.sda = 1'b1;
                     done          = 1'b1;
                  end
               end
               PH_WRITE: begin
                  if (cur_state.step_index == SEG_FIRST ||
                      cur_state.step_index == SEG_THIRD) begin
                     nxt_state.scl        = 1'b1;
                     nxt_state.step_index = cur_state.step_index + 2'd1;
                     nxt_state.hold_count = hold_len;
                  end else if (cur_state.step_index == SEG_SECOND) begin
                     nxt_state.bit_count  = bit_inc;
                     nxt_state.scl        = 1'b0;
                     nxt_state.hold_count = hold_len;
                     if (bit_inc < BITS_PER_BYTE) begin
                        nxt_state.shift_reg  = shift_left;
                        nxt_state.sda        = shift_left[7];
                        nxt_state.step_index = SEG_FIRST;
                     end else begin
                        nxt_state.sda_drive  = 1'b0;
                        nxt_state.step_index = SEG_THIRD;
                     end
                  end else begin
                     nxt_state.ack = req.sda_in;
                     nxt_state.scl = 1'b0;
                     done          = 1'b1;
                  end
               end
               PH_READ: begin
                  if (cur_state.step_index == SEG_FIRST) begin
                     nxt_state.scl        = 1'b1;
                     nxt_state.step_index = SEG_SECOND;
                     nxt_state.hold_count = hold_len;
                  end else begin
                     nxt_state.shift_reg = {cur_state.shift_reg[6:0], req.sda_in};
                     nxt_state.bit_count = bit_inc;
                     nxt_state.scl       = 1'b0;
                     if (bit_inc < BITS_PER_BYTE) begin
                        nxt_state.step_index = SEG_FIRST;
                        nxt_state.hold_count = hold_len;
                     end else begin
                        nxt_state.rd_byte = {cur_state.shift_reg[6:0], req.sda_in};
                        done              = 1'b1;
                     end
                  end
               end
               PH_ACK, PH_NACK: begin
                  if (cur_state.step_index == SEG_FIRST) begin
                     nxt_state.step_index = SEG_SECOND;
                     nxt_state.hold_count = hold_len;
                  end else if (cur_state.step_index == SEG_SECOND) begin
                     nxt_state.scl        = 1'b1;
                     nxt_state.step_index = SEG_THIRD;
                     nxt_state.hold_count = hold_len;
                  end else begin
                     nxt_state.scl = 1'b0;
                     if (cur_state.phase == PH_ACK) begin
                        nxt_state.sda = 1'b1;
                     end
                     done = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               nxt_state.phase      = PH_IDLE;
               nxt_state.step_index = SEG_FIRST;
               nxt_state.hold_count = '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/i2cm_checker.sv =====
// Port-level checker for the I2C bit-level master core, bound to the top level below.
// Depends on i2cm_pkg and i2c_bit_level_master_core.
`default_nettype none

module i2cm_checker
   import i2cm_pkg::*;
(
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire i2cm_rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result word present right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result word changed or dropped.");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("Done flagged while still busy.");

   a_one_per_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted word produced no result word.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("New word accepted while result word is stalled.");

endmodule

bind i2c_bit_level_master_core i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
